// ===== design/spb_pkg.sv =====
// Shared types, constants and codes of the seed site matrix builder.
`default_nettype none
package spb_pkg;

   // default sizing of the builder
   localparam int DEF_MAX_WIDTH      = 32;
   localparam int DEF_COUNT_BITS     = 20;
   localparam int DEF_MISMATCH_LIMIT = 1;

   // fixed widths of the result fields
   localparam int PROB_BITS  = 17;
   localparam int SITE_BITS  = 20;
   localparam int COL_BITS   = 5;
   localparam int LEN_BITS   = 6;
   localparam int SEED_BITS  = 64;
   localparam int PC_BITS    = 16;

   // best distance when no window was scored
   localparam logic [LEN_BITS-1:0] NO_BEST = 6'd63;
   localparam logic [LEN_BITS-1:0] RUN_MAX = 6'd63;

   // register indexes of the control port
   typedef enum logic [1:0] {
      CSR_SEED_BASES  = 2'd0,
      CSR_SEED_LENGTH = 2'd1,
      CSR_PSEUDOCOUNT = 2'd2
   } csr_index_type;

   // input word
   typedef struct packed {
      logic       action;
      logic [2:0] base_code;
      logic       sequence_end;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [COL_BITS-1:0]  column_index;
      logic [PROB_BITS-1:0] prob_a;
      logic [PROB_BITS-1:0] prob_c;
      logic [PROB_BITS-1:0] prob_g;
      logic [PROB_BITS-1:0] prob_t;
      logic [1:0]           consensus_base;
      logic [SITE_BITS-1:0] site_total;
      logic                 empty_matrix;
      logic                 last;
   } rsp_word_type;

   // controls broadcast to every column cell
   typedef struct packed {
      logic win_shift;
      logic best_take;
      logic seq_clear;
      logic site_add;
      logic cnt_shift;
      logic cnt_clear;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== design/seed_site_pwm_builder_core.sv =====
// Top level: seed window scoring, column cell chain and finalize sequencer.
//
// Bases are taken one per cycle with no gap while busy is low: each accepted
// base shifts the window along a chain of column cells, scores it against the
// seed and, on the last base of a sequence, adds the best window, if within
// the mismatch limit, to the column counts in the same cycle. A finalize word
// holds busy high while the counts stream out of the chain, one column at a
// time, into a four-lane divider yielding one quotient bit per cycle; each
// column takes a load, 17 divide steps and a step to present the result. An
// empty matrix is answered in the next cycle. Each result appears for exactly
// one cycle with rsp_strobe high and must be taken then; it cannot be held off.
`default_nettype none
module seed_site_pwm_builder_core #(
   parameter int MaxWidth      = spb_pkg::DEF_MAX_WIDTH,
   parameter int CountBits     = spb_pkg::DEF_COUNT_BITS,
   parameter int MismatchLimit = spb_pkg::DEF_MISMATCH_LIMIT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire spb_pkg::req_word_type    req_word,
   output logic                          rsp_strobe,
   output spb_pkg::rsp_word_type         rsp_word,
   input  wire logic                     csr_write_en,
   input  wire logic [1:0]               csr_index,
   input  wire logic [63:0]              csr_data
);
   import spb_pkg::*;

   localparam int SumBits = CountBits + 2;
   localparam int DenBits = SumBits + 8 + 1;
   localparam int NumBits = CountBits + 8 + 1;
   localparam logic [CountBits-1:0] CountMax = '1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_DIV  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [SEED_BITS-1:0]   seed_ff;
   logic [LEN_BITS-1:0]    len_ff;
   logic [PC_BITS-1:0]     pc_ff;
   logic [LEN_BITS-1:0]    len_eff;

   logic [LEN_BITS-1:0]    run_ff, run_in;
   logic [LEN_BITS-1:0]    best_ff, best_in;
   logic [CountBits-1:0]   site_ff, site_in;
   logic [LEN_BITS-1:0]    col_ff, col_in;
   logic [1:0]             cons_ff, cons_in;
   logic                   zero_ff, zero_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   cell_ctl_type           ctl;
   logic                   accept, base_ok, score, take;
   logic [LEN_BITS-1:0]    win_mismatches;
   logic [MaxWidth-1:0]    mis_vec;
   logic [1:0]             win_chain [MaxWidth+1];
   logic [4*CountBits-1:0] cnt_chain [MaxWidth+1];

   logic [SumBits-1:0]     col_sum;
   logic [DenBits-1:0]     den;
   logic [4*NumBits-1:0]   num_vec;
   logic                   div_load, div_done;
   logic [4*PROB_BITS-1:0] quot;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         len_ff  <= 6'd8;
         pc_ff   <= 16'd256;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEED_BASES:  seed_ff <= csr_data;
            CSR_SEED_LENGTH: len_ff  <= csr_data[LEN_BITS-1:0];
            CSR_PSEUDOCOUNT: pc_ff   <= csr_data[PC_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign len_eff = (len_ff > LEN_BITS'(MaxWidth)) ? LEN_BITS'(MaxWidth) : len_ff;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign base_ok = accept && !req_word.action && (req_word.base_code < 3'd4);

   // column cells, counts drain toward cell zero
   assign win_chain[MaxWidth] = 2'd0;
   assign cnt_chain[MaxWidth] = '0;

   for (genvar i = 0; i < MaxWidth; i++) begin : g_cell
      spb_cell #(.CountBits(CountBits)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .in_len    (LEN_BITS'(i) < len_eff),
         .is_tail   (LEN_BITS'(i + 1) == len_eff),
         .code      (req_word.base_code[1:0]),
         .seed_base (seed_ff[2*i +: 2]),
         .win_next  (win_chain[i+1]),
         .cnt_next  (cnt_chain[i+1]),
         .win       (win_chain[i]),
         .mismatch  (mis_vec[i]),
         .cnt       (cnt_chain[i])
      );
   end

   // score the shifted window and track the sequence
   always_comb begin
      run_in = run_ff;
      if (accept && !req_word.action) begin
         if (!base_ok) begin
            run_in = '0;
         end else if (run_ff != RUN_MAX) begin
            run_in = run_ff + LEN_BITS'(1);
         end
      end
   end

   assign win_mismatches = LEN_BITS'($countones(mis_vec));
   assign score   = base_ok && (len_eff != '0) && (run_in >= len_eff);
   assign take    = score && (win_mismatches < best_ff);
   assign best_in = take ? win_mismatches : best_ff;

   // column sums and divider operands from cell zero
   always_comb begin
      col_sum = '0;
      for (int b = 0; b < 4; b++) begin
         col_sum = col_sum + SumBits'(cnt_chain[0][b*CountBits +: CountBits]);
         num_vec[b*NumBits +: NumBits] =
            {1'b0, cnt_chain[0][b*CountBits +: CountBits], 8'd0} + NumBits'(pc_ff);
      end
      den = {1'b0, col_sum, 8'd0} + DenBits'({pc_ff, 2'b00});
   end

   // consensus: greatest count, lower base on ties
   always_comb begin
      cons_in = 2'd0;
      for (int b = 1; b < 4; b++) begin
         if (cnt_chain[0][b*CountBits +: CountBits] >
             cnt_chain[0][cons_in*CountBits +: CountBits]) begin
            cons_in = 2'(b);
         end
      end
      zero_in = (den == '0);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      site_in       = site_ff;
      col_in        = col_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      ctl           = '0;
      div_load      = 1'b0;

      ctl.win_shift = base_ok && (len_eff != '0);
      ctl.best_take = take;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_word.action && req_word.sequence_end) begin
               ctl.seq_clear = 1'b1;
               if (best_in <= LEN_BITS'(MismatchLimit) && site_ff != CountMax) begin
                  ctl.site_add = 1'b1;
                  site_in      = site_ff + CountBits'(1);
               end
            end else if (accept && req_word.action) begin
               if (site_ff == '0 || len_eff == '0) begin
                  rsp_strobe_in            = 1'b1;
                  rsp_word_in              = '0;
                  rsp_word_in.site_total   = SITE_BITS'(site_ff);
                  rsp_word_in.empty_matrix = 1'b1;
                  rsp_word_in.last         = 1'b1;
                  ctl.cnt_clear            = 1'b1;
                  site_in                  = '0;
               end else begin
                  col_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            div_load      = 1'b1;
            ctl.cnt_shift = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_strobe_in              = 1'b1;
               rsp_word_in.column_index   = col_ff[COL_BITS-1:0];
               rsp_word_in.prob_a         = zero_ff ? '0 : quot[0*PROB_BITS +: PROB_BITS];
               rsp_word_in.prob_c         = zero_ff ? '0 : quot[1*PROB_BITS +: PROB_BITS];
               rsp_word_in.prob_g         = zero_ff ? '0 : quot[2*PROB_BITS +: PROB_BITS];
               rsp_word_in.prob_t         = zero_ff ? '0 : quot[3*PROB_BITS +: PROB_BITS];
               rsp_word_in.consensus_base = zero_ff ? 2'd0 : cons_ff;
               rsp_word_in.site_total     = SITE_BITS'(site_ff);
               rsp_word_in.empty_matrix   = 1'b0;
               rsp_word_in.last           = (col_ff + LEN_BITS'(1) == len_eff);
               if (col_ff + LEN_BITS'(1) == len_eff) begin
                  ctl.cnt_clear = 1'b1;
                  site_in       = '0;
                  state_in      = ST_IDLE;
               end else begin
                  col_in   = col_ff + LEN_BITS'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   spb_div #(.NumBits(NumBits), .DenBits(DenBits)) u_div (
      .clock (clock),
      .reset (reset),
      .load  (div_load),
      .num   (num_vec),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         run_ff        <= '0;
         best_ff       <= NO_BEST;
         site_ff       <= '0;
         col_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_ff        <= ctl.seq_clear ? '0 : run_in;
         best_ff       <= ctl.seq_clear ? NO_BEST : best_in;
         site_ff       <= site_in;
         col_ff        <= col_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // hold column extras and the result word
   always_ff @(posedge clock) begin
      if (div_load) begin
         cons_ff <= cons_in;
         zero_ff <= zero_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
`default_nettype wire

// ===== design/spb_cell.sv =====
// One motif column: window base, best base and four base counts.
`default_nettype none
module spb_cell #(
   parameter int CountBits = 20
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire spb_pkg::cell_ctl_type    ctl,
   input  wire logic                     in_len,
   input  wire logic                     is_tail,
   input  wire logic [1:0]               code,
   input  wire logic [1:0]               seed_base,
   input  wire logic [1:0]               win_next,
   input  wire logic [4*CountBits-1:0]   cnt_next,
   output logic      [1:0]               win,
   output logic                          mismatch,
   output logic      [4*CountBits-1:0]   cnt
);
   import spb_pkg::*;

   logic [1:0]             win_ff, win_in, win_shifted;
   logic [1:0]             best_ff, best_in;
   logic [4*CountBits-1:0] cnt_ff, cnt_in;

   // shift the window toward column zero, new base enters at the tail
   always_comb begin
      win_shifted = win_ff;
      if (ctl.win_shift) begin
         if (is_tail) begin
            win_shifted = code;
         end else if (in_len) begin
            win_shifted = win_next;
         end else begin
            win_shifted = 2'd0;
         end
      end
   end

   assign mismatch = in_len && (win_shifted != seed_base);
   assign best_in  = ctl.best_take ? win_shifted : best_ff;
   assign win_in   = ctl.seq_clear ? 2'd0 : win_shifted;

   // count the best base as a site, stream counts out on finalize, or clear them
   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.cnt_clear) begin
         cnt_in = '0;
      end else if (ctl.cnt_shift) begin
         cnt_in = cnt_next;
      end else if (ctl.site_add && in_len) begin
         cnt_in[best_in*CountBits +: CountBits] =
            cnt_ff[best_in*CountBits +: CountBits] + CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= 2'd0;
         best_ff <= 2'd0;
         cnt_ff  <= '0;
      end else begin
         win_ff  <= win_in;
         best_ff <= ctl.seq_clear ? 2'd0 : best_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign win = win_ff;
   assign cnt = cnt_ff;

endmodule
`default_nettype wire

// ===== design/spb_div.sv =====
// Four-lane radix-2 divider sharing one denominator, one quotient bit a cycle.
`default_nettype none
module spb_div #(
   parameter int NumBits = 29,
   parameter int DenBits = 31
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                load,
   input  wire logic [4*NumBits-1:0]                num,
   input  wire logic [DenBits-1:0]                  den,
   output logic                                     done,
   output logic      [4*spb_pkg::PROB_BITS-1:0]     quot
);
   import spb_pkg::*;

   localparam int StepBits = $clog2(PROB_BITS);

   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [StepBits-1:0]          step_ff, step_in;
   logic [DenBits-1:0]           den_ff;
   logic [4*DenBits-1:0]         rem_ff, rem_in;
   logic [4*PROB_BITS-1:0]       quot_ff, quot_in;
   logic [DenBits:0]             trial;

   // each lane: first step compares as is, later steps shift left first
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      trial   = '0;
      if (load) begin
         for (int k = 0; k < 4; k++) begin
            rem_in[k*DenBits +: DenBits] = DenBits'(num[k*NumBits +: NumBits]);
         end
         quot_in = '0;
         run_in  = 1'b1;
         step_in = '0;
      end else if (run_ff) begin
         for (int k = 0; k < 4; k++) begin
            if (step_ff == '0) begin
               trial = {1'b0, rem_ff[k*DenBits +: DenBits]};
            end else begin
               trial = {rem_ff[k*DenBits +: DenBits], 1'b0};
            end
            if (trial >= {1'b0, den_ff}) begin
               rem_in[k*DenBits +: DenBits] = DenBits'(trial - {1'b0, den_ff});
               quot_in[k*PROB_BITS +: PROB_BITS] =
                  {quot_ff[k*PROB_BITS +: PROB_BITS-1], 1'b1};
            end else begin
               rem_in[k*DenBits +: DenBits] = DenBits'(trial);
               quot_in[k*PROB_BITS +: PROB_BITS] =
                  {quot_ff[k*PROB_BITS +: PROB_BITS-1], 1'b0};
            end
         end
         step_in = step_ff + StepBits'(1);
         if (step_ff == StepBits'(PROB_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         den_ff <= den;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire
